FILE: rtl/core/amed_pkg.sv
package amed_pkg;

    localparam int unsigned CELL_W   = 6;
    localparam int unsigned CELL_MAX = 63;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PIDX_W   = 5;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ERRORS     = 1'b1;

    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_TEXT    = 1'b1;

    // Signals broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic              pat_we;
        logic [PIDX_W-1:0] pat_idx;
        logic [BYTE_W-1:0] pat_byte;
        logic [BYTE_W-1:0] text_byte;
        logic              line_init;
    } amed_bcast_t;

endpackage

FILE: rtl/core/amed_item_if.sv
interface amed_item_if;
    import amed_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [PIDX_W-1:0] pattern_index;
    logic [BYTE_W-1:0] data_byte;
    logic              line_end;

    modport source (output valid, mode, pattern_index, data_byte, line_end, input ready);
    modport sink   (input valid, mode, pattern_index, data_byte, line_end, output ready);
endinterface

FILE: rtl/core/amed_result_if.sv
interface amed_result_if;
    import amed_pkg::*;

    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] end_distance;
    logic              match_here;
    logic              line_hit;
    logic              line_done;

    modport source (output valid, end_distance, match_here, line_hit, line_done, input ready);
    modport sink   (input valid, end_distance, match_here, line_hit, line_done, output ready);
endinterface

FILE: rtl/core/amed_cfg_if.sv
interface amed_cfg_if;
    import amed_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/amed_cell.sv
module amed_cell #(
    parameter int unsigned POS = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  amed_pkg::amed_bcast_t         bcast,
    input  logic                          tok_in,
    input  logic                          is_last,
    input  logic [amed_pkg::CELL_W-1:0]   diag_in,
    input  logic [amed_pkg::CELL_W-1:0]   left_in,
    output logic                          tok_out,
    output logic [amed_pkg::CELL_W-1:0]   col,
    output logic [amed_pkg::CELL_W-1:0]   old_col
);
    import amed_pkg::*;

    localparam logic [CELL_W-1:0] INIT_VAL =
        (POS + 1 > CELL_MAX) ? CELL_W'(CELL_MAX) : CELL_W'(POS + 1);

    logic [BYTE_W-1:0] pat_reg;
    logic [CELL_W-1:0] col_reg;
    logic [CELL_W-1:0] col_next;
    logic [CELL_W-1:0] old_reg;
    logic              tok_reg;
    logic [CELL_W:0]   cost_diag;
    logic [CELL_W:0]   cost_up;
    logic [CELL_W:0]   cost_left;
    logic [CELL_W:0]   best;

    always_comb
    begin
        cost_diag = {1'b0, diag_in} + ((pat_reg != bcast.text_byte) ? 7'd1 : 7'd0);
        cost_up   = {1'b0, col_reg} + 7'd1;
        cost_left = {1'b0, left_in} + 7'd1;
        best = cost_diag;
        if (cost_up < best)
        begin
            best = cost_up;
        end
        if (cost_left < best)
        begin
            best = cost_left;
        end
        col_next = (best > 7'(CELL_MAX)) ? CELL_W'(CELL_MAX) : best[CELL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= INIT_VAL;
            tok_reg <= 1'b0;
        end
        else
        begin
            if (bcast.line_init)
            begin
                col_reg <= INIT_VAL;
            end
            else if (tok_in)
            begin
                col_reg <= col_next;
            end
            tok_reg <= tok_in && !is_last;
        end
    end

    // The value before this update is the diagonal term for the next cell down.
    always_ff @(posedge clk)
    begin
        if (tok_in)
        begin
            old_reg <= col_reg;
        end
        if (bcast.pat_we && (32'(bcast.pat_idx) == POS))
        begin
            pat_reg <= bcast.pat_byte;
        end
    end

    assign tok_out = tok_reg;
    assign col     = col_reg;
    assign old_col = old_reg;

endmodule

FILE: rtl/core/approximate_match_edit_distance.sv
// Channel  | Direction | Payload
// item     | in        | mode, pattern_index, data_byte, line_end
// result   | out       | end_distance, match_here, line_hit, line_done
// cfg      | in        | index, data (register write)
//
// A pattern write gives no result.
// A text byte walks down the cell row one cell per cycle, so its result is
// registered after the m-th cell updates, m being the pattern length in use;
// the next request is taken once that result has entered the output register.
// A waiting result does not block requests; a stalled result holds the row.
// Reset puts every column cell at its row number and clears the line flag.
module approximate_match_edit_distance #(
    parameter int unsigned MAX_PATTERN = 32
) (
    input logic        clk,
    input logic        rst_n,
    amed_item_if.sink   item,
    amed_result_if.source result,
    amed_cfg_if.sink    cfg
);
    import amed_pkg::*;

    localparam int unsigned IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_t;

    state_t                state_reg;
    logic [CFG_DATA_W-1:0] len_reg;
    logic [CFG_DATA_W-1:0] maxerr_reg;
    logic                  hit_reg;
    logic                  start_reg;
    logic [BYTE_W-1:0]     text_reg;
    logic                  last_reg;
    logic                  out_valid_reg;
    logic [CELL_W-1:0]     out_dist_reg;
    logic                  out_match_reg;
    logic                  out_hit_reg;
    logic                  out_done_reg;

    logic [IW-1:0]         m_last;
    logic [MAX_PATTERN-1:0] tok_in_vec;
    logic [MAX_PATTERN-1:0] tok_out_vec;
    logic [MAX_PATTERN-1:0] last_mask;
    logic [CELL_W-1:0]     col_w [MAX_PATTERN];
    logic [CELL_W-1:0]     old_w [MAX_PATTERN];
    amed_bcast_t           bcast;
    logic                  accept;
    logic                  finish;
    logic                  out_free;
    logic                  fin_load;
    logic [CELL_W-1:0]     end_dist;
    logic                  match;
    logic                  hit_next;

    always_comb
    begin
        if (len_reg == '0)
        begin
            m_last = '0;
        end
        else if (32'(len_reg) > MAX_PATTERN)
        begin
            m_last = IW'(MAX_PATTERN - 1);
        end
        else
        begin
            m_last = IW'(32'(len_reg) - 32'd1);
        end
    end

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;
    assign out_free   = !out_valid_reg || result.ready;
    assign finish     = |(tok_in_vec & last_mask);
    assign fin_load   = (state_reg == S_FIN) && out_free;

    assign end_dist = col_w[m_last];
    assign match    = (end_dist <= maxerr_reg);
    assign hit_next = hit_reg || match;

    always_comb
    begin
        bcast.pat_we    = accept && (item.mode == MODE_PATTERN);
        bcast.pat_idx   = item.pattern_index;
        bcast.pat_byte  = item.data_byte;
        bcast.text_byte = text_reg;
        bcast.line_init = fin_load && last_reg;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++)
        begin : g_row
            logic [CELL_W-1:0] diag_in;
            logic [CELL_W-1:0] left_in;

            assign last_mask[g] = (32'(m_last) == g);
            if (g == 0)
            begin : g_top
                // The row above the first cell is always zero.
                assign tok_in_vec[g] = start_reg;
                assign diag_in = '0;
                assign left_in = '0;
            end
            else
            begin : g_inner
                assign tok_in_vec[g] = tok_out_vec[g-1];
                assign diag_in = old_w[g-1];
                assign left_in = col_w[g-1];
            end

            amed_cell #(.POS(g)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .bcast   (bcast),
                .tok_in  (tok_in_vec[g]),
                .is_last (last_mask[g]),
                .diag_in (diag_in),
                .left_in (left_in),
                .tok_out (tok_out_vec[g]),
                .col     (col_w[g]),
                .old_col (old_w[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= CFG_DATA_W'(1);
            maxerr_reg    <= '0;
            hit_reg       <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_PATTERN_LENGTH: len_reg <= cfg.data;
                    REG_MAX_ERRORS:     maxerr_reg <= cfg.data;
                    default:            ;
                endcase
            end

            start_reg <= accept && (item.mode == MODE_TEXT);

            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (item.mode == MODE_TEXT))
                    begin
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (finish)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        hit_reg       <= last_reg ? 1'b0 : hit_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            text_reg <= item.data_byte;
            last_reg <= item.line_end;
        end
        if (fin_load)
        begin
            out_dist_reg  <= end_dist;
            out_match_reg <= match;
            out_hit_reg   <= hit_next;
            out_done_reg  <= last_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.end_distance = out_dist_reg;
    assign result.match_here   = out_match_reg;
    assign result.line_hit     = out_hit_reg;
    assign result.line_done    = out_done_reg;

    a_one_front: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_in_vec))
        else $error("more than one cell active at once");

    a_no_request_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !(|tok_in_vec))
        else $error("request taken while a column update is in flight");

    a_finish_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && finish) |=> (state_reg == S_FIN))
        else $error("column update finished without a result stage");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fin_load |=> result.valid)
        else $error("finished result did not reach the output register");

endmodule

FILE: tb/sv/approximate_match_edit_distance_test.sv
module approximate_match_edit_distance_test;
    timeunit 1ns;
    timeprecision 1ps;
    import amed_pkg::*;

    localparam int PATTERN_DEPTH = 32;
    localparam int SETTLE_CYCLES = PATTERN_DEPTH + 8;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [CELL_W-1:0] end_distance;
        logic              match_here;
        logic              line_hit;
        logic              line_done;
    } score_t;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_PATTERN, STALL_HEAVY} stall_t;

    logic clk = 1'b0;
    logic rst_n;

    amed_item_if   item_bus ();
    amed_result_if result_bus ();
    amed_cfg_if    cfg_bus ();

    approximate_match_edit_distance #(
        .MAX_PATTERN(PATTERN_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_bus),
        .result(result_bus),
        .cfg(cfg_bus)
    );

    // Own copy of the matcher state.
    logic [BYTE_W-1:0] pattern_mem [PATTERN_DEPTH];
    logic [CELL_W-1:0] dist_col [PATTERN_DEPTH+1];
    logic              line_hit_q;
    logic [CELL_W-1:0] len_reg;
    logic [CELL_W-1:0] max_err_reg;

    score_t expected_scores [$];
    int     bad_results = 0;
    int     cycle_count = 0;
    int     burst_left = 0;
    int     holdoff_cycles = 0;
    int     random_sent = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void reset_column();
        for (int i = 0; i <= PATTERN_DEPTH; i++)
        begin
            dist_col[i] = CELL_W'(i);
        end
    endfunction

    function automatic int length_in_use();
        if (len_reg == 0)
            return 1;
        if (len_reg > PATTERN_DEPTH)
            return PATTERN_DEPTH;
        return int'(len_reg);
    endfunction

    // One column of the edit-distance table; the top cell stays 0 so that a
    // match may begin anywhere in the line.
    function automatic score_t edit_column_step(logic [BYTE_W-1:0] text, logic last);
        score_t s;
        int     m;
        int     diag;
        int     left;
        int     up;
        int     best;
        m = length_in_use();
        diag = int'(dist_col[0]);
        left = 0;
        dist_col[0] = '0;
        for (int i = 1; i <= m; i++)
        begin
            up = int'(dist_col[i]);
            best = diag + ((pattern_mem[i-1] == text) ? 0 : 1);
            if (up + 1 < best)
                best = up + 1;
            if (left + 1 < best)
                best = left + 1;
            if (best > int'(CELL_MAX))
                best = int'(CELL_MAX);
            diag = up;
            dist_col[i] = CELL_W'(best);
            left = best;
        end
        s.end_distance = dist_col[m];
        s.match_here = (dist_col[m] <= max_err_reg);
        if (s.match_here)
            line_hit_q = 1'b1;
        s.line_hit = line_hit_q;
        s.line_done = last;
        if (last)
        begin
            reset_column();
            line_hit_q = 1'b0;
        end
        return s;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_letter(int span);
        if (span >= 255)
            return BYTE_W'($urandom_range(0, 255));
        return BYTE_W'(8'h61 + $urandom_range(0, span));
    endfunction

    // Offers one request; the sender idles between bursts of random length.
    task automatic send_request(logic mode, logic [PIDX_W-1:0] idx,
                                logic [BYTE_W-1:0] data, logic last);
        int     gap;
        score_t s;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(1, 6);
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                       : $urandom_range(1, 12);
        end
        item_bus.valid <= 1'b1;
        item_bus.mode <= mode;
        item_bus.pattern_index <= idx;
        item_bus.data_byte <= data;
        item_bus.line_end <= last;
        do @(posedge clk); while (!item_bus.ready);
        burst_left--;
        if (mode == MODE_TEXT)
        begin
            s = edit_column_step(data, last);
            expected_scores = {expected_scores, s};
        end
        else
            pattern_mem[idx] = data;
    endtask

    task automatic send_text(logic [BYTE_W-1:0] data, logic last);
        send_request(MODE_TEXT, PIDX_W'($urandom_range(0, 31)), data, last);
    endtask

    // The line end flag of a pattern write is ignored, so it is left random.
    task automatic send_pattern(int idx, logic [BYTE_W-1:0] data);
        send_request(MODE_PATTERN, PIDX_W'(idx), data, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_word(string s, logic end_line);
        for (int i = 0; i < s.len(); i++)
        begin
            send_text(s[i], end_line && (i == s.len() - 1));
        end
    endtask

    task automatic load_pattern(int count, int span);
        for (int i = 0; i < count; i++)
        begin
            send_pattern(i, pick_letter(span));
        end
    endtask

    // Feeds the stored pattern back as text, starting at a given position.
    task automatic replay_text(int first, int count, logic end_line);
        for (int i = 0; i < count; i++)
        begin
            send_text(pattern_mem[(first + i) % length_in_use()],
                      end_line && (i == count - 1));
        end
    endtask

    // A pattern write gives no result, so the row is given time to settle
    // once the last expected result is in.
    task automatic wait_idle();
        item_bus.valid <= 1'b0;
        while (expected_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_search(int len, int max_err);
        wait_idle();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= REG_PATTERN_LENGTH;
        cfg_bus.data <= CFG_DATA_W'(len);
        do @(posedge clk); while (!cfg_bus.ready);
        len_reg = CFG_DATA_W'(len);
        cfg_bus.index <= REG_MAX_ERRORS;
        cfg_bus.data <= CFG_DATA_W'(max_err);
        do @(posedge clk); while (!cfg_bus.ready);
        max_err_reg = CFG_DATA_W'(max_err);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic test_directed();
        string word;
        set_search(4, 1);
        word = "abcd";
        for (int i = 0; i < word.len(); i++)
        begin
            send_pattern(i, word[i]);
        end
        send_pattern(31, 8'hFF);
        // Exact hit, then a deletion and an insertion within one error.
        send_word("abcd", 1'b0);
        send_word("abd", 1'b0);
        send_word("abXcd", 1'b1);
        send_text(8'h00, 1'b0);
        send_text(8'hFF, 1'b1);
        // A length of zero behaves as a single pattern byte.
        set_search(0, 0);
        send_word("ab", 1'b1);
        set_search(4, 63);
        send_word("zz", 1'b1);
    endtask

    task automatic test_length_limits();
        wait_idle();
        load_pattern(PATTERN_DEPTH, 3);
        // Lengths above the store behave as the full store.
        set_search(63, 32);
        replay_text(0, PATTERN_DEPTH + 4, 1'b1);
        set_search(32, 0);
        replay_text(0, PATTERN_DEPTH, 1'b0);
        replay_text(5, 4, 1'b1);
        set_search(1, 63);
        replay_text(0, 3, 1'b1);
    endtask

    // Cells beyond the old length keep their last values when it grows.
    task automatic test_length_change();
        set_search(8, 2);
        replay_text(0, 10, 1'b0);
        set_search(20, 3);
        replay_text(2, 12, 1'b0);
        set_search(3, 1);
        replay_text(0, 6, 1'b1);
    endtask

    task automatic test_pressure();
        set_search(6, 1);
        load_pattern(6, 2);
        burst_left = 1000;
        holdoff_cycles = 300;
        replay_text(0, 40, 1'b1);
        burst_left = 0;
        wait_idle();
    endtask

    task automatic test_random_search();
        int r;
        int len;
        int used;
        int max_err;
        int span;
        int count;
        int pos;
        int line_left;
        logic last;
        while (random_sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                len = 0;
            else if (r == 1)
                len = 63;
            else if (r == 2)
                len = PATTERN_DEPTH;
            else if (r < 12)
                len = $urandom_range(1, 6);
            else if (r < 17)
                len = $urandom_range(7, 16);
            else
                len = $urandom_range(17, 31);
            used = (len == 0) ? 1 : ((len > PATTERN_DEPTH) ? PATTERN_DEPTH : len);
            r = $urandom_range(0, 9);
            if (r == 0)
                max_err = 0;
            else if (r == 1)
                max_err = 32;
            else if (r == 2)
                max_err = 63;
            else
                max_err = $urandom_range(0, used / 3 + 1);
            span = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 5);
            set_search(len, max_err);
            load_pattern(used, span);
            random_sent += used;
            count = $urandom_range(40, 160);
            pos = 0;
            line_left = $urandom_range(1, 3 * used + 10);
            for (int k = 0; k < count; k++)
            begin
                r = $urandom_range(0, 99);
                last = (line_left == 1);
                if (r < 4)
                    send_pattern($urandom_range(0, PATTERN_DEPTH - 1), pick_letter(span));
                else
                begin
                    if (r < 70)
                        send_text(pattern_mem[pos % used], last);
                    else if (r < 80)
                    begin
                        // Skips a pattern byte, giving a deletion.
                        pos++;
                        send_text(pattern_mem[pos % used], last);
                    end
                    else if (r < 90)
                        send_text(pick_letter(span), last);
                    else
                        send_text(BYTE_W'($urandom_range(0, 255)), last);
                    pos++;
                    line_left--;
                    if (last)
                    begin
                        line_left = $urandom_range(1, 3 * used + 10);
                        pos = $urandom_range(0, used - 1);
                    end
                end
                random_sent++;
            end
        end
    endtask

    // Receiver ready follows a stall style that is picked anew at random once its run of random length ends.
    initial
    begin
        stall_t style;
        int     style_left;
        int     tick;
        result_bus.ready = 1'b0;
        style = STALL_NONE;
        style_left = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            if (style_left == 0)
            begin
                style = stall_t'($urandom_range(0, 3));
                style_left = $urandom_range(100, 500);
            end
            style_left--;
            tick++;
            if (holdoff_cycles > 0)
            begin
                holdoff_cycles--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                case (style)
                    STALL_NONE:    result_bus.ready <= 1'b1;
                    STALL_COIN:    result_bus.ready <= 1'($urandom_range(0, 1));
                    STALL_PATTERN: result_bus.ready <= ((tick % 7) >= 3);
                    default:       result_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        score_t got;
        score_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got.end_distance = result_bus.end_distance;
            got.match_here = result_bus.match_here;
            got.line_hit = result_bus.line_hit;
            got.line_done = result_bus.line_done;
            if (expected_scores.size() == 0)
            begin
                bad_results++;
                if (bad_results <= REPORT_LIMIT)
                    $display("cycle %0d: unexpected result dist=%0d match=%b hit=%b done=%b",
                             cycle_count, got.end_distance, got.match_here, got.line_hit,
                             got.line_done);
            end
            else
            begin
                want = expected_scores.pop_front();
                if (got !== want)
                begin
                    bad_results++;
                    if (bad_results <= REPORT_LIMIT)
                    begin
                        $display("cycle %0d: expected dist=%0d match=%b hit=%b done=%b",
                                 cycle_count, want.end_distance, want.match_here,
                                 want.line_hit, want.line_done);
                        $display("cycle %0d: got      dist=%0d match=%b hit=%b done=%b",
                                 cycle_count, got.end_distance, got.match_here,
                                 got.line_hit, got.line_done);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item_bus.valid = 1'b0;
        item_bus.mode = MODE_PATTERN;
        item_bus.pattern_index = '0;
        item_bus.data_byte = '0;
        item_bus.line_end = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_PATTERN_LENGTH;
        cfg_bus.data = '0;
        for (int i = 0; i < PATTERN_DEPTH; i++)
        begin
            pattern_mem[i] = '0;
        end
        reset_column();
        line_hit_q = 1'b0;
        len_reg = 1;
        max_err_reg = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_length_limits();
        test_length_change();
        test_pressure();
        test_random_search();
        wait_idle();

        if (bad_results == 0 && expected_scores.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/amed_pkg.sv
rtl/core/amed_item_if.sv
rtl/core/amed_result_if.sv
rtl/core/amed_cfg_if.sv
rtl/core/amed_cell.sv
rtl/core/approximate_match_edit_distance.sv
tb/sv/approximate_match_edit_distance_test.sv
